[src/binary_max_heap_queue_macros.svh]
// ----------------------------------------------------------------------------
// Binary max-heap queue assertion macros
// Shared forms for the concurrent checks of the heap queue, clocked on clk
// and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BINARY_MAX_HEAP_QUEUE_MACROS_SVH
`define BINARY_MAX_HEAP_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BMHQ_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BMHQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/bmhq_pkg.sv]
// ----------------------------------------------------------------------------
// Heap queue package
// Sizes, entry and control word types, and the microcode program of the
// binary max-heap queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

    localparam int CAPACITY      = 16;
    localparam int PRIORITY_BITS = 4;
    localparam int TAG_BITS      = 8;

    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CHILD_W  = IDX_W + 2;
    localparam int MODE_W   = 2;
    localparam int S_DATA_W = ((PRIORITY_BITS + TAG_BITS + 7) / 8) * 8;
    localparam int M_DATA_W = ((PRIORITY_BITS + TAG_BITS + CNT_W + 7) / 8) * 8;
    localparam int M_USER_W = 2;
    localparam int PC_W     = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_PEEK   = 2'd2,
        MODE_NOP    = 2'd3
    } mode_t;

    typedef struct packed {
        logic [TAG_BITS-1:0]      tag;
        logic [PRIORITY_BITS-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
    } mem_req_t;

    typedef logic [PC_W-1:0] step_t;

    localparam step_t STEP_IDLE      = 4'd0;
    localparam step_t STEP_INS_CHK   = 4'd1;
    localparam step_t STEP_UP_TEST   = 4'd2;
    localparam step_t STEP_UP_CMP    = 4'd3;
    localparam step_t STEP_PLACE     = 4'd4;
    localparam step_t STEP_REM_CHK   = 4'd5;
    localparam step_t STEP_REM_LAST  = 4'd6;
    localparam step_t STEP_REM_LOAD  = 4'd7;
    localparam step_t STEP_DN_TEST   = 4'd8;
    localparam step_t STEP_DN_LEFT   = 4'd9;
    localparam step_t STEP_DN_RIGHT  = 4'd10;
    localparam step_t STEP_DN_SWAP   = 4'd11;
    localparam step_t STEP_PEEK_RD   = 4'd12;
    localparam step_t STEP_PEEK_OUT  = 4'd13;
    localparam step_t STEP_OVF       = 4'd14;
    localparam step_t STEP_EMIT      = 4'd15;

    typedef enum logic [2:0] {
        RD_NONE   = 3'd0,
        RD_ROOT   = 3'd1,
        RD_LAST   = 3'd2,
        RD_PARENT = 3'd3,
        RD_LEFT   = 3'd4,
        RD_RIGHT  = 3'd5
    } rd_sel_t;

    typedef enum logic [3:0] {
        OP_NONE       = 4'd0,
        OP_ACCEPT     = 4'd1,
        OP_INS_LOAD   = 4'd2,
        OP_UP_MOVE    = 4'd3,
        OP_PLACE      = 4'd4,
        OP_TAKE_ROOT  = 4'd5,
        OP_DOWN_START = 4'd6,
        OP_LOAD_LEFT  = 4'd7,
        OP_LOAD_RIGHT = 4'd8,
        OP_DOWN_MOVE  = 4'd9,
        OP_SET_OVF    = 4'd10,
        OP_EMIT       = 4'd11
    } op_t;

    typedef enum logic [3:0] {
        C_NONE     = 4'd0,
        C_NO_ITEM  = 4'd1,
        C_FULL     = 4'd2,
        C_EMPTY    = 4'd3,
        C_POS_ZERO = 4'd4,
        C_NOT_UP   = 4'd5,
        C_NO_LEFT  = 4'd6,
        C_NO_RIGHT = 4'd7,
        C_BEST_CUR = 4'd8,
        C_OUT_BUSY = 4'd9
    } cond_t;

    // When the condition holds the step jumps to tgt_t and its operation is
    // skipped; otherwise the operation runs and the step goes on to tgt_f,
    // or to the entry point of the item's mode when dispatch is set.
    typedef struct packed {
        rd_sel_t rd;
        op_t     op;
        cond_t   cond;
        logic    dispatch;
        step_t   tgt_t;
        step_t   tgt_f;
    } ucode_t;

    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        unique case (step)
            STEP_IDLE:     w = '{RD_NONE,   OP_ACCEPT,     C_NO_ITEM,  1'b1,
                                 STEP_IDLE,     STEP_IDLE};
            STEP_INS_CHK:  w = '{RD_NONE,   OP_INS_LOAD,   C_FULL,     1'b0,
                                 STEP_OVF,      STEP_UP_TEST};
            STEP_UP_TEST:  w = '{RD_PARENT, OP_NONE,       C_POS_ZERO, 1'b0,
                                 STEP_PLACE,    STEP_UP_CMP};
            STEP_UP_CMP:   w = '{RD_NONE,   OP_UP_MOVE,    C_NOT_UP,   1'b0,
                                 STEP_PLACE,    STEP_UP_TEST};
            STEP_PLACE:    w = '{RD_NONE,   OP_PLACE,      C_NONE,     1'b0,
                                 STEP_EMIT,     STEP_EMIT};
            STEP_REM_CHK:  w = '{RD_ROOT,   OP_NONE,       C_EMPTY,    1'b0,
                                 STEP_EMIT,     STEP_REM_LAST};
            STEP_REM_LAST: w = '{RD_LAST,   OP_TAKE_ROOT,  C_NONE,     1'b0,
                                 STEP_REM_LOAD, STEP_REM_LOAD};
            STEP_REM_LOAD: w = '{RD_NONE,   OP_DOWN_START, C_NONE,     1'b0,
                                 STEP_DN_TEST,  STEP_DN_TEST};
            STEP_DN_TEST:  w = '{RD_LEFT,   OP_NONE,       C_NO_LEFT,  1'b0,
                                 STEP_PLACE,    STEP_DN_LEFT};
            STEP_DN_LEFT:  w = '{RD_RIGHT,  OP_LOAD_LEFT,  C_NONE,     1'b0,
                                 STEP_DN_RIGHT, STEP_DN_RIGHT};
            STEP_DN_RIGHT: w = '{RD_NONE,   OP_LOAD_RIGHT, C_NO_RIGHT, 1'b0,
                                 STEP_DN_SWAP,  STEP_DN_SWAP};
            STEP_DN_SWAP:  w = '{RD_NONE,   OP_DOWN_MOVE,  C_BEST_CUR, 1'b0,
                                 STEP_PLACE,    STEP_DN_TEST};
            STEP_PEEK_RD:  w = '{RD_ROOT,   OP_NONE,       C_EMPTY,    1'b0,
                                 STEP_EMIT,     STEP_PEEK_OUT};
            STEP_PEEK_OUT: w = '{RD_NONE,   OP_TAKE_ROOT,  C_NONE,     1'b0,
                                 STEP_EMIT,     STEP_EMIT};
            STEP_OVF:      w = '{RD_NONE,   OP_SET_OVF,    C_NONE,     1'b0,
                                 STEP_EMIT,     STEP_EMIT};
            STEP_EMIT:     w = '{RD_NONE,   OP_EMIT,       C_OUT_BUSY, 1'b0,
                                 STEP_EMIT,     STEP_IDLE};
        endcase
        return w;
    endfunction

    function automatic step_t mode_entry(input mode_t mode);
        step_t s;
        unique case (mode)
            MODE_INSERT: s = STEP_INS_CHK;
            MODE_REMOVE: s = STEP_REM_CHK;
            MODE_PEEK:   s = STEP_PEEK_RD;
            MODE_NOP:    s = STEP_EMIT;
        endcase
        return s;
    endfunction

endpackage

[src/bmhq_store.sv]
// ----------------------------------------------------------------------------
// Heap entry store
// Single-write, single-read memory of heap entries with a registered read.
// ----------------------------------------------------------------------------
module bmhq_store
(
    input  logic               clk,
    input  bmhq_pkg::mem_req_t req,
    output bmhq_pkg::entry_t   rd_data
);

    bmhq_pkg::entry_t mem [bmhq_pkg::CAPACITY];
    bmhq_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/binary_max_heap_queue.sv]
// ----------------------------------------------------------------------------
// Binary max-heap priority queue
// Item modes: unused mode, peek, insert and remove-max.
// One item is in work at a time; the next is taken the cycle after its result is
// registered. Each sift level up runs UP_TEST, UP_CMP; down, DN_TEST to DN_SWAP.
// rst_n clears the step counter, entry count and result valid at once.
// ----------------------------------------------------------------------------
module binary_max_heap_queue
(
    input  logic                          clk,
    input  logic                          rst_n,

    // Input items.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // tdata: new_priority, new_tag, then zero padding.
    input  logic [bmhq_pkg::S_DATA_W-1:0] s_tdata,
    // tuser: mode.
    input  logic [bmhq_pkg::MODE_W-1:0]   s_tuser,

    // Result items.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // tdata: out_priority, out_tag, occupancy, then zero padding.
    output logic [bmhq_pkg::M_DATA_W-1:0] m_tdata,
    // tuser: found, overflow.
    output logic [bmhq_pkg::M_USER_W-1:0] m_tuser
);

    `include "binary_max_heap_queue_macros.svh"

    // The block is a small microcoded engine. A step counter addresses the
    // control program in the package; each control word selects a store read
    // address, one datapath operation and a conditional jump. The heap lives
    // in the store, and the entry being sifted is held in cur_reg so that it
    // is written only once, at its final position: each level moves just the
    // parent (going up) or the winning child (going down) into the hole.

    bmhq_pkg::step_t  pc_reg, pc_next;
    bmhq_pkg::ucode_t uw;
    logic             cond_hit;
    logic             exec;

    bmhq_pkg::entry_t cur_reg, cur_next;
    bmhq_pkg::entry_t best_reg, best_next;
    logic [bmhq_pkg::IDX_W-1:0] best_idx_reg, best_idx_next;
    logic             best_cur_reg, best_cur_next;
    logic [bmhq_pkg::IDX_W-1:0] pos_reg, pos_next;
    logic [bmhq_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    logic             res_found_reg, res_found_next;
    logic             res_ovf_reg, res_ovf_next;
    bmhq_pkg::entry_t res_entry_reg, res_entry_next;

    logic             out_valid_reg, out_valid_next;
    logic             out_found_reg, out_found_next;
    logic             out_ovf_reg, out_ovf_next;
    bmhq_pkg::entry_t out_entry_reg, out_entry_next;
    logic [bmhq_pkg::CNT_W-1:0] out_cnt_reg, out_cnt_next;

    bmhq_pkg::mem_req_t mem_req;
    bmhq_pkg::entry_t   rd_data;
    bmhq_pkg::entry_t   in_entry;

    logic [bmhq_pkg::IDX_W-1:0]   parent_idx;
    logic [bmhq_pkg::CHILD_W-1:0] left_wide;
    logic [bmhq_pkg::CHILD_W-1:0] right_wide;
    logic [bmhq_pkg::CHILD_W-1:0] cnt_wide;
    logic [bmhq_pkg::CNT_W-1:0]   last_wide;

    bmhq_store u_store
    (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // Input fields: priority in the low bits of tdata, tag above it.
    assign in_entry.prio = s_tdata[bmhq_pkg::PRIORITY_BITS-1:0];
    assign in_entry.tag  = s_tdata[bmhq_pkg::PRIORITY_BITS +: bmhq_pkg::TAG_BITS];

    // Tree navigation. The parent is only used when pos is not the root, and
    // the children are range-checked against the count in their full width
    // before their low bits are used as addresses.
    assign parent_idx = (pos_reg - 1'b1) >> 1;
    assign left_wide  = {1'b0, pos_reg, 1'b1};
    assign right_wide = left_wide + 1'b1;
    assign cnt_wide   = bmhq_pkg::CHILD_W'(cnt_reg);
    assign last_wide  = cnt_reg - 1'b1;

    assign uw = bmhq_pkg::ucode_rom(pc_reg);

    always_comb
    begin
        unique case (uw.cond)
            bmhq_pkg::C_NONE:     cond_hit = 1'b0;
            bmhq_pkg::C_NO_ITEM:  cond_hit = !s_tvalid;
            bmhq_pkg::C_FULL:     cond_hit = (cnt_reg == bmhq_pkg::CNT_W'(bmhq_pkg::CAPACITY));
            bmhq_pkg::C_EMPTY:    cond_hit = (cnt_reg == '0);
            bmhq_pkg::C_POS_ZERO: cond_hit = (pos_reg == '0);
            bmhq_pkg::C_NOT_UP:   cond_hit = !(cur_reg.prio > rd_data.prio);
            bmhq_pkg::C_NO_LEFT:  cond_hit = (left_wide >= cnt_wide);
            bmhq_pkg::C_NO_RIGHT: cond_hit = (right_wide >= cnt_wide);
            bmhq_pkg::C_BEST_CUR: cond_hit = best_cur_reg;
            bmhq_pkg::C_OUT_BUSY: cond_hit = out_valid_reg && !m_tready;
            default:              cond_hit = 1'b0;
        endcase
    end

    assign exec = !cond_hit;

    always_comb
    begin
        priority if (cond_hit)
        begin
            pc_next = uw.tgt_t;
        end
        else if (uw.dispatch)
        begin
            pc_next = bmhq_pkg::mode_entry(bmhq_pkg::mode_t'(s_tuser));
        end
        else
        begin
            pc_next = uw.tgt_f;
        end
    end

    // Datapath operations and the store's read port.
    always_comb
    begin
        cur_next       = cur_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        best_cur_next  = best_cur_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        res_found_next = res_found_reg;
        res_ovf_next   = res_ovf_reg;
        res_entry_next = res_entry_reg;
        out_found_next = out_found_reg;
        out_ovf_next   = out_ovf_reg;
        out_entry_next = out_entry_reg;
        out_cnt_next   = out_cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = pos_reg;
        mem_req.wr_data = cur_reg;

        // Store read port: the read is issued whether or not the step jumps,
        // as a stray read only refreshes the read register.
        mem_req.rd_en = (uw.rd != bmhq_pkg::RD_NONE);
        unique case (uw.rd)
            bmhq_pkg::RD_NONE:   mem_req.rd_addr = '0;
            bmhq_pkg::RD_ROOT:   mem_req.rd_addr = '0;
            bmhq_pkg::RD_LAST:   mem_req.rd_addr = last_wide[bmhq_pkg::IDX_W-1:0];
            bmhq_pkg::RD_PARENT: mem_req.rd_addr = parent_idx;
            bmhq_pkg::RD_LEFT:   mem_req.rd_addr = left_wide[bmhq_pkg::IDX_W-1:0];
            bmhq_pkg::RD_RIGHT:  mem_req.rd_addr = right_wide[bmhq_pkg::IDX_W-1:0];
            default:             mem_req.rd_addr = '0;
        endcase

        if (exec)
        begin
            unique case (uw.op)
                bmhq_pkg::OP_NONE:
                begin
                end
                bmhq_pkg::OP_ACCEPT:
                begin
                    cur_next       = in_entry;
                    res_found_next = 1'b0;
                    res_ovf_next   = 1'b0;
                    res_entry_next = '0;
                end
                bmhq_pkg::OP_INS_LOAD:
                begin
                    pos_next = cnt_reg[bmhq_pkg::IDX_W-1:0];
                    cnt_next = cnt_reg + 1'b1;
                end
                bmhq_pkg::OP_UP_MOVE:
                begin
                    // The smaller parent drops into the hole.
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_data = rd_data;
                    pos_next        = parent_idx;
                end
                bmhq_pkg::OP_PLACE:
                begin
                    mem_req.wr_en = 1'b1;
                end
                bmhq_pkg::OP_TAKE_ROOT:
                begin
                    res_found_next = 1'b1;
                    res_entry_next = rd_data;
                end
                bmhq_pkg::OP_DOWN_START:
                begin
                    // The last entry becomes the one that sinks from the root.
                    cur_next = rd_data;
                    cnt_next = cnt_reg - 1'b1;
                    pos_next = '0;
                end
                bmhq_pkg::OP_LOAD_LEFT:
                begin
                    if (rd_data.prio > cur_reg.prio)
                    begin
                        best_next     = rd_data;
                        best_idx_next = left_wide[bmhq_pkg::IDX_W-1:0];
                        best_cur_next = 1'b0;
                    end
                    else
                    begin
                        best_next     = cur_reg;
                        best_cur_next = 1'b1;
                    end
                end
                bmhq_pkg::OP_LOAD_RIGHT:
                begin
                    // Strictly greater, so the left child keeps a tie.
                    if (rd_data.prio > best_reg.prio)
                    begin
                        best_next     = rd_data;
                        best_idx_next = right_wide[bmhq_pkg::IDX_W-1:0];
                        best_cur_next = 1'b0;
                    end
                end
                bmhq_pkg::OP_DOWN_MOVE:
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_data = best_reg;
                    pos_next        = best_idx_reg;
                end
                bmhq_pkg::OP_SET_OVF:
                begin
                    res_ovf_next = 1'b1;
                end
                bmhq_pkg::OP_EMIT:
                begin
                    out_valid_next = 1'b1;
                    out_found_next = res_found_reg;
                    out_ovf_next   = res_ovf_reg;
                    out_entry_next = res_entry_reg;
                    out_cnt_next   = cnt_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= bmhq_pkg::STEP_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        best_reg      <= best_next;
        best_idx_reg  <= best_idx_next;
        best_cur_reg  <= best_cur_next;
        pos_reg       <= pos_next;
        res_found_reg <= res_found_next;
        res_ovf_reg   <= res_ovf_next;
        res_entry_reg <= res_entry_next;
        out_found_reg <= out_found_next;
        out_ovf_reg   <= out_ovf_next;
        out_entry_reg <= out_entry_next;
        out_cnt_reg   <= out_cnt_next;
    end

    // An item is taken only while the sequencer waits at its idle step; the
    // result register lets the next item in while the last result waits.
    assign s_tready = (pc_reg == bmhq_pkg::STEP_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = bmhq_pkg::M_DATA_W'({out_cnt_reg, out_entry_reg});
    assign m_tuser  = {out_ovf_reg, out_found_reg};

    `BMHQ_ASSERT(a_cnt_bound, 1'b1, cnt_reg <= bmhq_pkg::CNT_W'(bmhq_pkg::CAPACITY), "entry count beyond capacity")
    `BMHQ_ASSERT(a_found_or_ovf, m_tvalid, !(m_tuser[0] && m_tuser[1]), "result both found and overflow")
    `BMHQ_ASSERT(a_wr_in_heap, mem_req.wr_en && (cnt_reg != '0), bmhq_pkg::CNT_W'(mem_req.wr_addr) < cnt_reg, "store write outside the heap")
    `BMHQ_ASSERT_NEXT(a_accept_starts, s_tvalid && s_tready, pc_reg != bmhq_pkg::STEP_IDLE, "accepted item did not start the program")

endmodule

[test/tb_binary_max_heap_queue.sv]
// ----------------------------------------------------------------------------
// Heap queue testbench
// Sends insert, remove-maximum, peek and unused-mode items into the heap
// queue and checks every result item against a predictor kept in step with
// the accepted items. A short table of directed items comes first, followed
// by random traffic in fill, drain and mixed phases, with random idling on
// both sides and one long stall of the result side.
// ----------------------------------------------------------------------------
module tb_binary_max_heap_queue;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM    = 1300;
    localparam int QUIET_TAIL  = 150;
    localparam int HOLD_AT     = 400;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 40;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_DIRECTED  = 25;

    // One result item as the block reports it.
    typedef struct packed {
        logic                               found;
        logic [bmhq_pkg::PRIORITY_BITS-1:0] prio;
        logic [bmhq_pkg::TAG_BITS-1:0]      tag;
        logic [bmhq_pkg::CNT_W-1:0]         occ;
        logic                               ovf;
    } heap_reply_t;

    // A directed row carries a typed reply only where it is obvious.
    typedef struct packed {
        bmhq_pkg::mode_t                    mode;
        logic [bmhq_pkg::PRIORITY_BITS-1:0] prio;
        logic [bmhq_pkg::TAG_BITS-1:0]      tag;
        logic                               typed;
        heap_reply_t                        reply;
    } dir_row_t;

    typedef enum int {
        PH_FILL,
        PH_DRAIN,
        PH_MIXED
    } traffic_phase_t;

    // Rows: empty-heap cases and the unused mode, an extreme entry in and
    // out again, sixteen inserts with repeated priorities to fill the heap,
    // an insert into the full heap, the unused mode when full, one remove.
    localparam dir_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{bmhq_pkg::MODE_PEEK,   4'd0,  8'd0,   1'b1, '{1'b0, 4'd0,  8'd0,   5'd0,  1'b0}},
        '{bmhq_pkg::MODE_REMOVE, 4'd0,  8'd0,   1'b1, '{1'b0, 4'd0,  8'd0,   5'd0,  1'b0}},
        '{bmhq_pkg::MODE_NOP,    4'd15, 8'd255, 1'b1, '{1'b0, 4'd0,  8'd0,   5'd0,  1'b0}},
        '{bmhq_pkg::MODE_INSERT, 4'd15, 8'd255, 1'b1, '{1'b0, 4'd0,  8'd0,   5'd1,  1'b0}},
        '{bmhq_pkg::MODE_PEEK,   4'd0,  8'd0,   1'b1, '{1'b1, 4'd15, 8'd255, 5'd1,  1'b0}},
        '{bmhq_pkg::MODE_REMOVE, 4'd0,  8'd0,   1'b1, '{1'b1, 4'd15, 8'd255, 5'd0,  1'b0}},
        '{bmhq_pkg::MODE_INSERT, 4'd7,  8'd10,  1'b0, '0},
        '{bmhq_pkg::MODE_INSERT, 4'd7,  8'd11,  1'b0, '0},
        '{bmhq_pkg::MODE_INSERT, 4'd9,  8'd12,  1'b0, '0},
        '{bmhq_pkg::MODE_INSERT, 4'd7,  8'd13,  1'b0, '0},
        '{bmhq_pkg::MODE_INSERT, 4'd15, 8'd14,  1'b0, '0},
        '{bmhq_pkg::MODE_INSERT, 4'd0,  8'd0,   1'b0, '0},
        '{bmhq_pkg::MODE_INSERT, 4'd9,  8'd16,  1'b0, '0},
        '{bmhq_pkg::MODE_INSERT, 4'd9,  8'd17,  1'b0, '0},
        '{bmhq_pkg::MODE_INSERT, 4'd3,  8'd18,  1'b0, '0},
        '{bmhq_pkg::MODE_INSERT, 4'd15, 8'd19,  1'b0, '0},
        '{bmhq_pkg::MODE_INSERT, 4'd7,  8'd20,  1'b0, '0},
        '{bmhq_pkg::MODE_INSERT, 4'd1,  8'd21,  1'b0, '0},
        '{bmhq_pkg::MODE_INSERT, 4'd12, 8'd22,  1'b0, '0},
        '{bmhq_pkg::MODE_INSERT, 4'd12, 8'd23,  1'b0, '0},
        '{bmhq_pkg::MODE_INSERT, 4'd5,  8'd24,  1'b0, '0},
        '{bmhq_pkg::MODE_INSERT, 4'd8,  8'd170, 1'b0, '0},
        '{bmhq_pkg::MODE_INSERT, 4'd15, 8'd255, 1'b1, '{1'b0, 4'd0,  8'd0,   5'd16, 1'b1}},
        '{bmhq_pkg::MODE_NOP,    4'd0,  8'd0,   1'b1, '{1'b0, 4'd0,  8'd0,   5'd16, 1'b0}},
        '{bmhq_pkg::MODE_REMOVE, 4'd0,  8'd0,   1'b0, '0}
    };

    logic                          clk;
    logic                          rst_n    = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [bmhq_pkg::S_DATA_W-1:0] s_tdata  = '0;
    logic [bmhq_pkg::MODE_W-1:0]   s_tuser  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [bmhq_pkg::M_DATA_W-1:0] m_tdata;
    logic [bmhq_pkg::M_USER_W-1:0] m_tuser;

    // Expected result items, oldest first.
    heap_reply_t awaited_replies [$];
    int          fail_count  = 0;
    int          cycle_count = 0;

    // Flags and idling rates of the item sender and the result receiver.
    bit quiet_tail   = 1'b0;
    bit hold_request = 1'b0;
    bit hold_taken   = 1'b0;
    int tx_gap_pct   = 30;
    int rx_stall_pct = 30;

    // Predicted heap contents and entry count.
    bmhq_pkg::entry_t model_heap [bmhq_pkg::CAPACITY];
    int               model_count = 0;

    binary_max_heap_queue i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void model_swap(input int a, input int b);
        bmhq_pkg::entry_t t;
        t             = model_heap[a];
        model_heap[a] = model_heap[b];
        model_heap[b] = t;
    endfunction

    // Applies one operation to the predicted heap and returns the result
    // item that the block should produce for it. Priorities compare strictly,
    // so equal entries never swap and the left child wins a tie.
    function automatic heap_reply_t heap_apply(input bmhq_pkg::mode_t mode,
                                               input logic [bmhq_pkg::PRIORITY_BITS-1:0] prio,
                                               input logic [bmhq_pkg::TAG_BITS-1:0] tag);
        heap_reply_t r;
        int          pos;
        int          parent;
        int          left_idx;
        int          right_idx;
        int          best;
        bit          settled;
        r       = '0;
        settled = 1'b0;
        case (mode)
            bmhq_pkg::MODE_INSERT:
            begin
                if (model_count >= bmhq_pkg::CAPACITY)
                begin
                    r.ovf = 1'b1;
                end
                else
                begin
                    model_heap[model_count].prio = prio;
                    model_heap[model_count].tag  = tag;
                    pos = model_count;
                    model_count++;
                    while (pos > 0 && !settled)
                    begin
                        parent = (pos - 1) / 2;
                        if (model_heap[pos].prio > model_heap[parent].prio)
                        begin
                            model_swap(pos, parent);
                            pos = parent;
                        end
                        else
                        begin
                            settled = 1'b1;
                        end
                    end
                end
            end
            bmhq_pkg::MODE_REMOVE:
            begin
                if (model_count > 0)
                begin
                    r.found       = 1'b1;
                    r.prio        = model_heap[0].prio;
                    r.tag         = model_heap[0].tag;
                    model_heap[0] = model_heap[model_count - 1];
                    model_count--;
                    pos = 0;
                    while (!settled)
                    begin
                        left_idx  = 2 * pos + 1;
                        right_idx = 2 * pos + 2;
                        best      = pos;
                        if (left_idx < model_count &&
                            model_heap[left_idx].prio > model_heap[best].prio)
                            best = left_idx;
                        if (right_idx < model_count &&
                            model_heap[right_idx].prio > model_heap[best].prio)
                            best = right_idx;
                        if (best == pos)
                        begin
                            settled = 1'b1;
                        end
                        else
                        begin
                            model_swap(pos, best);
                            pos = best;
                        end
                    end
                end
            end
            bmhq_pkg::MODE_PEEK:
            begin
                if (model_count > 0)
                begin
                    r.found = 1'b1;
                    r.prio  = model_heap[0].prio;
                    r.tag   = model_heap[0].tag;
                end
            end
            default:
            begin
            end
        endcase
        r.occ = model_count[bmhq_pkg::CNT_W-1:0];
        return r;
    endfunction

    task automatic sender_pause(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Offers one item and waits for the edge that accepts it. The predictor
    // always advances; a typed reply, where given, is what gets expected.
    task automatic present_item(input bmhq_pkg::mode_t mode,
                                input logic [bmhq_pkg::PRIORITY_BITS-1:0] prio,
                                input logic [bmhq_pkg::TAG_BITS-1:0] tag,
                                input bit typed,
                                input heap_reply_t typed_reply);
        heap_reply_t predicted;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= bmhq_pkg::S_DATA_W'({tag, prio});
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predicted = heap_apply(mode, prio, tag);
        awaited_replies.insert(awaited_replies.size(), typed ? typed_reply : predicted);
    endtask

    // Item sender: reset, the directed table, then the random phases.
    initial
    begin
        traffic_phase_t                     phase;
        int                                 phase_left;
        int                                 roll;
        bmhq_pkg::mode_t                    pick_mode;
        logic [bmhq_pkg::PRIORITY_BITS-1:0] pick_prio;
        logic [bmhq_pkg::TAG_BITS-1:0]      pick_tag;
        int                                 settle;

        phase      = PH_FILL;
        phase_left = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if ($urandom_range(99) < 30)
                sender_pause($urandom_range(1, 8));
            present_item(DIRECTED_ROWS[i].mode, DIRECTED_ROWS[i].prio,
                         DIRECTED_ROWS[i].tag, DIRECTED_ROWS[i].typed,
                         DIRECTED_ROWS[i].reply);
        end

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (phase_left == 0)
            begin
                // A new phase also picks how busy both sides are, so that
                // stretches without any idling appear as well.
                phase      = traffic_phase_t'($urandom_range(2));
                phase_left = $urandom_range(20, 60);
                case ($urandom_range(2))
                    0: tx_gap_pct = 0;
                    1: tx_gap_pct = 20;
                    default: tx_gap_pct = 50;
                endcase
                case ($urandom_range(2))
                    0: rx_stall_pct = 0;
                    1: rx_stall_pct = 20;
                    default: rx_stall_pct = 50;
                endcase
            end
            phase_left--;

            if (i == HOLD_AT)
            begin
                // The receiver stops for a long while; keep offering items
                // back to back so that the block has to stall its input.
                hold_request = 1'b1;
                tx_gap_pct   = 0;
            end
            if (i == N_RANDOM - QUIET_TAIL)
            begin
                quiet_tail = 1'b1;
                tx_gap_pct = 0;
            end

            roll = $urandom_range(99);
            case (phase)
                PH_FILL:
                    pick_mode = (roll < 70) ? bmhq_pkg::MODE_INSERT :
                                (roll < 85) ? bmhq_pkg::MODE_REMOVE :
                                (roll < 97) ? bmhq_pkg::MODE_PEEK : bmhq_pkg::MODE_NOP;
                PH_DRAIN:
                    pick_mode = (roll < 20) ? bmhq_pkg::MODE_INSERT :
                                (roll < 80) ? bmhq_pkg::MODE_REMOVE :
                                (roll < 97) ? bmhq_pkg::MODE_PEEK : bmhq_pkg::MODE_NOP;
                default:
                    pick_mode = (roll < 45) ? bmhq_pkg::MODE_INSERT :
                                (roll < 80) ? bmhq_pkg::MODE_REMOVE :
                                (roll < 97) ? bmhq_pkg::MODE_PEEK : bmhq_pkg::MODE_NOP;
            endcase
            // A narrow band of priorities half of the time, to provoke ties.
            if ($urandom_range(1) == 1)
                pick_prio = bmhq_pkg::PRIORITY_BITS'($urandom_range(15));
            else
                pick_prio = bmhq_pkg::PRIORITY_BITS'($urandom_range(6, 8));
            pick_tag = bmhq_pkg::TAG_BITS'($urandom_range(255));

            // No idling at all once the quiet tail has begun.
            if (!quiet_tail && tx_gap_pct > 0 && $urandom_range(99) < tx_gap_pct)
                sender_pause($urandom_range(1, 8));
            present_item(pick_mode, pick_prio, pick_tag, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (awaited_replies.size() != 0) @(posedge clk);
        // Let a late or extra result item show itself before closing.
        settle = DRAIN_WAIT;
        repeat (settle) @(posedge clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Result receiver: random stall bursts, the single long hold-off, and
    // always ready once the quiet tail of the run has begun.
    initial
    begin
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!quiet_tail && rx_stall_pct > 0 &&
                     $urandom_range(99) < rx_stall_pct)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat (quiet_tail ? 1 : $urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // Result checker: every accepted result item is compared with the
    // oldest expectation, field by field.
    always @(posedge clk)
    begin
        heap_reply_t want;
        heap_reply_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.found = m_tuser[0];
            got.ovf   = m_tuser[1];
            got.prio  = m_tdata[bmhq_pkg::PRIORITY_BITS-1:0];
            got.tag   = m_tdata[bmhq_pkg::PRIORITY_BITS +: bmhq_pkg::TAG_BITS];
            got.occ   = m_tdata[bmhq_pkg::PRIORITY_BITS+bmhq_pkg::TAG_BITS +: bmhq_pkg::CNT_W];
            if (awaited_replies.size() == 0)
            begin
                $display("%0t: result item with none expected, got %p", $time, got);
                fail_count++;
            end
            else
            begin
                want = awaited_replies.pop_front();
                if (got.found !== want.found)
                begin
                    $display("%0t: found expected %0d got %0d", $time, want.found, got.found);
                    fail_count++;
                end
                if (got.prio !== want.prio)
                begin
                    $display("%0t: out_priority expected %0d got %0d",
                             $time, want.prio, got.prio);
                    fail_count++;
                end
                if (got.tag !== want.tag)
                begin
                    $display("%0t: out_tag expected %0d got %0d", $time, want.tag, got.tag);
                    fail_count++;
                end
                if (got.occ !== want.occ)
                begin
                    $display("%0t: occupancy expected %0d got %0d",
                             $time, want.occ, got.occ);
                    fail_count++;
                end
                if (got.ovf !== want.ovf)
                begin
                    $display("%0t: overflow expected %0d got %0d", $time, want.ovf, got.ovf);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: cycle limit reached with %0d result items outstanding",
                 $time, awaited_replies.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
